// ----- rtl/udtrs_pkg.sv -----
// Shared types, constants and codes for the transmit ring scheduler.
package udtrs_pkg;

    // Ring storage geometry.
    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int SIZE_W     = 11;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 11'd1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Result queue geometry.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = OUT_AW + 1;

    // Input queue geometry.
    localparam int IN_DEPTH = 2;
    localparam int IN_AW    = $clog2(IN_DEPTH);
    localparam int IN_CW    = IN_AW + 1;

    // Register indexes.
    localparam logic REG_SIZE  = 1'b0;
    localparam logic REG_TC_EN = 1'b1;

    // Item modes as they arrive on the mode field.
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_DONE  = 2'd1;
    localparam logic [1:0] MODE_TC    = 2'd2;
    localparam logic [1:0] MODE_FETCH = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;
    localparam logic [1:0] ST_IGNORE = 2'd3;

    // Item class decided in the front part.
    typedef enum logic [3:0] {
        KIND_BYTE  = 4'b0001,
        KIND_DONE  = 4'b0010,
        KIND_TC    = 4'b0100,
        KIND_FETCH = 4'b1000
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   data_byte;
        logic [15:0]  message_length;
        logic [9:0]   fetch_index;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        dma_start;
        logic [9:0]  dma_start_index;
        logic [9:0]  dma_count;
        logic        tc_wait;
        logic [9:0]  fill_count;
        logic [7:0]  read_byte;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              tc_en;
        logic              flush;
    } cfg_t;

endpackage

// ----- rtl/udtrs_front.sv -----
// Front part: input item queue and classification of each item.
module udtrs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           mode,
    input  logic [7:0]           data_byte,
    input  logic [15:0]          message_length,
    input  logic [9:0]           fetch_index,
    output logic                 item_valid,
    output udtrs_pkg::item_t     item,
    input  logic                 item_take
);
    import udtrs_pkg::*;

    item_t             q_reg [IN_DEPTH];
    logic [IN_AW-1:0]  wr_ptr_reg;
    logic [IN_AW-1:0]  rd_ptr_reg;
    logic [IN_CW-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;
    kind_t             kind;

    assign full       = (count_reg == IN_CW'(IN_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // Decode the mode into a one-hot class.
    always_comb
    begin
        case (mode)
            MODE_BYTE:  kind = KIND_BYTE;
            MODE_DONE:  kind = KIND_DONE;
            MODE_TC:    kind = KIND_TC;
            MODE_FETCH: kind = KIND_FETCH;
            default:    kind = KIND_FETCH;
        endcase
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= '{kind: kind, data_byte: data_byte,
                                   message_length: message_length,
                                   fetch_index: fetch_index};
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/udtrs_out_queue.sv -----
// Result queue between the back part and the result ports.
module udtrs_out_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  udtrs_pkg::result_t            wr_data,
    output logic [udtrs_pkg::OUT_CW-1:0]  count,
    output logic                          empty,
    input  logic                          pop,
    output udtrs_pkg::result_t            rd_data
);
    import udtrs_pkg::*;

    result_t            q_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]  wr_ptr_reg;
    logic [OUT_AW-1:0]  rd_ptr_reg;
    logic [OUT_CW-1:0]  count_reg;
    logic               do_pop;

    assign count   = count_reg;
    assign empty   = (count_reg == '0);
    assign rd_data = q_reg[rd_ptr_reg];
    assign do_pop  = pop && !empty;

    // Storage; the back part only writes when a slot is reserved.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/udtrs_back.sv -----
// Back part: ring state, message admission, DMA launch and ring memory.
module udtrs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  udtrs_pkg::cfg_t               cfg,
    input  logic                          item_valid,
    input  udtrs_pkg::item_t              item,
    output logic                          item_take,
    input  logic [udtrs_pkg::OUT_CW-1:0]  out_count,
    output logic                          res_valid,
    output udtrs_pkg::result_t            res
);
    import udtrs_pkg::*;

    typedef struct packed {
        logic       go;
        logic [9:0] span;
    } kick_t;

    // Ring state.
    logic [9:0]   head_reg, head_next;
    logic [9:0]   tail_reg, tail_next;
    logic [9:0]   xfer_len_reg, xfer_len_next;
    logic         active_reg, active_next;
    logic         waiting_reg, waiting_next;
    logic [15:0]  offset_reg, offset_next;
    logic         rejecting_reg, rejecting_next;

    // Result stage that lines up with the registered memory read.
    logic         s1_valid_reg;
    logic         s1_read_reg;
    result_t      s1_res_reg;

    // Ring memory.
    logic [7:0]          ring_mem [RING_DEPTH];
    logic [7:0]          rd_data_reg;
    logic                mem_we;
    logic [RING_AW-1:0]  mem_waddr;
    logic                mem_re;

    logic              exec;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] fill_cur;
    logic [SIZE_W-1:0] free_cur;
    logic              rej_now;
    logic [16:0]       off_p1;
    logic              last;
    logic [SIZE_W-1:0] adv;
    logic [9:0]        head_adv;
    logic [9:0]        tail_adv;
    kick_t             kk;
    logic [SIZE_W-1:0] fill_new;
    result_t           res_next;

    // Modular add of two ring positions, valid while the sum stays below twice the size.
    function automatic logic [9:0] wrap_add(input logic [SIZE_W-1:0] a,
                                            input logic [SIZE_W-1:0] b,
                                            input logic [SIZE_W-1:0] sz);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, sz})
        begin
            s = s - {1'b0, sz};
        end
        return s[9:0];
    endfunction

    // Bytes queued between tail and head.
    function automatic logic [SIZE_W-1:0] fill_of(input logic [9:0] h,
                                                  input logic [9:0] t,
                                                  input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] f;
        if (h >= t)
        begin
            f = {1'b0, h} - {1'b0, t};
        end
        else
        begin
            f = sz - {1'b0, t} + {1'b0, h};
        end
        return f;
    endfunction

    // Contiguous span a new transfer would cover.
    function automatic kick_t kick_of(input logic act, input logic [9:0] h,
                                      input logic [9:0] t,
                                      input logic [SIZE_W-1:0] sz);
        kick_t k;
        logic [SIZE_W-1:0] sp;
        if (h > t)
        begin
            sp = {1'b0, h} - {1'b0, t};
        end
        else
        begin
            sp = sz - {1'b0, t};
        end
        k.go   = !act && (h != t);
        k.span = sp[9:0];
        return k;
    endfunction

    assign size      = cfg.size;
    assign exec      = item_valid
                       && (({1'b0, out_count} + (OUT_CW + 1)'(s1_valid_reg))
                           < (OUT_CW + 1)'(OUT_DEPTH));
    assign item_take = exec;

    // Shared arithmetic on the current state.
    assign fill_cur = fill_of(head_reg, tail_reg, size);
    assign free_cur = size - SIZE_W'(1) - fill_cur;
    assign rej_now  = (offset_reg == '0) ? (item.message_length > {5'b0, free_cur})
                                         : rejecting_reg;
    assign off_p1   = {1'b0, offset_reg} + 17'd1;
    assign last     = (off_p1 >= {1'b0, item.message_length});
    assign adv      = (off_p1 > {6'b0, free_cur}) ? free_cur : off_p1[SIZE_W-1:0];
    assign head_adv = wrap_add({1'b0, head_reg}, adv, size);
    assign tail_adv = wrap_add({1'b0, tail_reg}, {1'b0, xfer_len_reg}, size);

    // Execute one item.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        xfer_len_next  = xfer_len_reg;
        active_next    = active_reg;
        waiting_next   = waiting_reg;
        offset_next    = offset_reg;
        rejecting_next = rejecting_reg;
        mem_we         = 1'b0;
        mem_waddr      = wrap_add({1'b0, head_reg}, offset_reg[SIZE_W-1:0], size);
        mem_re         = 1'b0;
        kk             = '0;
        res_next       = '0;
        res_next.status = ST_OK;

        case (item.kind)
            KIND_BYTE:
            begin
                if ((offset_reg == '0) && (item.message_length == '0))
                begin
                    res_next.status = ST_ZERO;
                end
                else
                begin
                    if (rej_now)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else if (offset_reg < {5'b0, free_cur})
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        res_next.status = ST_FULL;
                    end
                    if (last)
                    begin
                        if (!rej_now)
                        begin
                            head_next = head_adv;
                            kk = kick_of(active_reg, head_adv, tail_reg, size);
                        end
                        offset_next    = '0;
                        rejecting_next = 1'b0;
                    end
                    else
                    begin
                        offset_next    = off_p1[15:0];
                        rejecting_next = rej_now;
                    end
                end
            end
            KIND_DONE:
            begin
                if (!active_reg)
                begin
                    res_next.status = ST_IGNORE;
                end
                else
                begin
                    tail_next     = tail_adv;
                    xfer_len_next = '0;
                    active_next   = 1'b0;
                    if (head_reg != tail_adv)
                    begin
                        kk = kick_of(1'b0, head_reg, tail_adv, size);
                    end
                    else if (cfg.tc_en)
                    begin
                        waiting_next = 1'b1;
                    end
                end
            end
            KIND_TC:
            begin
                if (!cfg.tc_en || !waiting_reg)
                begin
                    res_next.status = ST_IGNORE;
                end
                else
                begin
                    waiting_next = 1'b0;
                end
            end
            KIND_FETCH:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
                res_next.status = ST_IGNORE;
            end
        endcase

        // Launch a transfer when the DMA engine is idle and data is queued.
        if (kk.go)
        begin
            xfer_len_next            = kk.span;
            active_next              = 1'b1;
            res_next.dma_start       = 1'b1;
            res_next.dma_start_index = (item.kind == KIND_DONE) ? tail_adv : tail_reg;
            res_next.dma_count       = kk.span;
            if (cfg.tc_en)
            begin
                waiting_next = 1'b0;
            end
        end

        fill_new            = fill_of(head_next, tail_next, size);
        res_next.tc_wait    = waiting_next;
        res_next.fill_count = fill_new[9:0];
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (exec && mem_we)
        begin
            ring_mem[mem_waddr] <= item.data_byte;
        end
        if (exec && mem_re)
        begin
            rd_data_reg <= ring_mem[item.fetch_index];
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            s1_res_reg  <= res_next;
            s1_read_reg <= mem_re;
        end
    end

    // Ring state and result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            xfer_len_reg  <= '0;
            active_reg    <= 1'b0;
            waiting_reg   <= 1'b0;
            offset_reg    <= '0;
            rejecting_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= exec;
            if (cfg.flush)
            begin
                head_reg      <= '0;
                tail_reg      <= '0;
                xfer_len_reg  <= '0;
                active_reg    <= 1'b0;
                waiting_reg   <= 1'b0;
                offset_reg    <= '0;
                rejecting_reg <= 1'b0;
            end
            else if (exec)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                xfer_len_reg  <= xfer_len_next;
                active_reg    <= active_next;
                waiting_reg   <= waiting_next;
                offset_reg    <= offset_next;
                rejecting_reg <= rejecting_next;
            end
        end
    end

    // Merge the read data into the staged result.
    always_comb
    begin
        res           = s1_res_reg;
        res.read_byte = s1_read_reg ? rd_data_reg : 8'd0;
    end

    assign res_valid = s1_valid_reg;

endmodule

// ----- rtl/uart_dma_tx_ring_scheduler.sv -----
// Top level of the transmit ring scheduler: register port and part wiring.
//
// Channel   Direction  Handshake               Payload
// input     in         push / full             mode, data_byte, message_length, fetch_index
// result    out        pop / empty             status, dma_start, dma_start_index,
//                                              dma_count, tc_wait, fill_count, read_byte
// config    in         psel, penable, pwrite   paddr, pwdata, prdata (pready tied high)
//
// An accepted item waits in a two-entry input queue, executes in the back part when there is
// room, then passes one result stage for the registered ring memory read before its result
// is written into the result queue and shown on the result ports.
// The back part executes one item per cycle while the four-entry result queue, counting the
// staged result, has room; full rises once both input queue entries are taken.
// Reset clears all control state; a ring size write flushes head, tail and message state.
module uart_dma_tx_ring_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   mode,
    input  logic [7:0]   data_byte,
    input  logic [15:0]  message_length,
    input  logic [9:0]   fetch_index,
    output logic         empty,
    input  logic         pop,
    output logic [1:0]   status,
    output logic         dma_start,
    output logic [9:0]   dma_start_index,
    output logic [9:0]   dma_count,
    output logic         tc_wait,
    output logic [9:0]   fill_count,
    output logic [7:0]   read_byte,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import udtrs_pkg::*;

    logic [SIZE_W-1:0]  size_cfg_reg;
    logic               tc_en_reg;
    logic               wr_strobe;
    logic               flush_reg;
    logic [SIZE_W-1:0]  eff_size;
    cfg_t               cfg;

    logic               item_valid;
    item_t              item;
    logic               item_take;
    logic [OUT_CW-1:0]  out_count;
    logic               res_valid;
    result_t            res;
    result_t            out_data;

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= SIZE_RESET;
            tc_en_reg    <= 1'b0;
            flush_reg    <= 1'b0;
        end
        else
        begin
            flush_reg <= 1'b0;
            if (wr_strobe)
            begin
                case (paddr[2])
                    REG_SIZE:
                    begin
                        size_cfg_reg <= pwdata[SIZE_W-1:0];
                        flush_reg    <= 1'b1;
                    end
                    REG_TC_EN:
                    begin
                        tc_en_reg <= pwdata[0];
                    end
                    default:
                    begin
                        tc_en_reg <= tc_en_reg;
                    end
                endcase
            end
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[2])
            REG_SIZE:  prdata = {{(32-SIZE_W){1'b0}}, size_cfg_reg};
            REG_TC_EN: prdata = {31'b0, tc_en_reg};
            default:   prdata = '0;
        endcase
    end

    // Clamp the ring size to the supported range.
    always_comb
    begin
        if (size_cfg_reg < SIZE_MIN)
        begin
            eff_size = SIZE_MIN;
        end
        else if (size_cfg_reg > SIZE_MAX)
        begin
            eff_size = SIZE_MAX;
        end
        else
        begin
            eff_size = size_cfg_reg;
        end
    end

    assign cfg = '{size: eff_size, tc_en: tc_en_reg, flush: flush_reg};

    udtrs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .mode           (mode),
        .data_byte      (data_byte),
        .message_length (message_length),
        .fetch_index    (fetch_index),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take)
    );

    udtrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_count  (out_count),
        .res_valid  (res_valid),
        .res        (res)
    );

    udtrs_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .count   (out_count),
        .empty   (empty),
        .pop     (pop),
        .rd_data (out_data)
    );

    assign status          = out_data.status;
    assign dma_start       = out_data.dma_start;
    assign dma_start_index = out_data.dma_start_index;
    assign dma_count       = out_data.dma_count;
    assign tc_wait         = out_data.tc_wait;
    assign fill_count      = out_data.fill_count;
    assign read_byte       = out_data.read_byte;

endmodule
